### design/ftad_pkg.sv
package ftad_pkg;

  localparam int unsigned FTAD_MAX_FANS = 5;

  localparam int unsigned IDX_W   = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned EXP_W   = 3;
  localparam int unsigned NUM_W   = 21;
  localparam int unsigned DEN_W   = COUNT_W + (1 << EXP_W) - 1;

  localparam logic [NUM_W-1:0]   RPM_NUMERATOR = NUM_W'(1350000);
  localparam logic [COUNT_W-1:0] COUNT_ABSENT  = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_HIGH    = 8'd192;
  localparam logic [COUNT_W-1:0] COUNT_LOW     = 8'd96;
  localparam logic [EXP_W-1:0]   EXP_MAX       = 3'd7;
  localparam logic [IDX_W-1:0]   FAN_COUNT_RST = 3'd5;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### design/ftad_if.sv
interface ftad_in_if import ftad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   fan_index;
  logic [COUNT_W-1:0] tach_count;

  modport source (output valid, fan_index, tach_count, input ready);
  modport sink   (input valid, fan_index, tach_count, output ready);
endinterface

interface ftad_out_if import ftad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] fan_channel;
  logic [NUM_W-1:0] rpm;
  logic [EXP_W-1:0] divisor_exponent;
  logic             divisor_changed;
  logic             accepted;

  modport source (output valid, fan_channel, rpm, divisor_exponent, divisor_changed,
                  accepted, input ready);
  modport sink   (input valid, fan_channel, rpm, divisor_exponent, divisor_changed,
                  accepted, output ready);
endinterface

interface ftad_cfg_if import ftad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### design/ftad_div.sv
module ftad_div
  import ftad_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DEN_W-1:0] denom,
  output div_sts_t         sts,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = denom;
      rem_nxt  = '0;
      quo_nxt  = RPM_NUMERATOR;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = quo_r;

endmodule

### design/fan_tach_autorange_divisor.sv
// Channel  | Dir | Handshake     | Beat contents
// in_bus   | in  | valid / ready | fan_index, tach_count
// out_bus  | out | valid / ready | fan_channel, rpm, divisor_exponent, divisor_changed, accepted
// cfg_bus  | in  | valid / ready | data = fan_count
//
// A beat whose count needs division passes, with the result taken at once, through
// an accept step, 21 steps of the shared restoring divider (one quotient bit each),
// a capture step and a hand-off step before the next beat can be accepted.
// Rejected indices and counts of 0 or 255 skip the divider and go straight to the hand-off.
// Reset (synchronous, rst_n low) clears all divisor exponents and sets fan_count to 5.
// A stalled result holds in the output register; in_bus and cfg_bus stay not ready.
module fan_tach_autorange_divisor
  import ftad_pkg::*;
#(
  parameter int unsigned MAX_FANS = FTAD_MAX_FANS
) (
  input  logic  clk,
  input  logic  rst_n,
  ftad_in_if.sink    in_bus,
  ftad_out_if.source out_bus,
  ftad_cfg_if.sink   cfg_bus
);

  localparam int unsigned SEL_W = (MAX_FANS > 1) ? $clog2(MAX_FANS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] fan_count_r;
  logic [EXP_W-1:0] fan_exp_r [MAX_FANS];

  logic [IDX_W-1:0] chan_r, chan_nxt;
  logic [NUM_W-1:0] rpm_r, rpm_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic [EXP_W-1:0] old_exp_r, old_exp_nxt;
  logic             chg_r, chg_nxt;
  logic             acc_r, acc_nxt;

  logic             in_fire;
  logic             idx_ok;
  logic [SEL_W-1:0] sel;
  logic [EXP_W-1:0] old_exp;
  logic [EXP_W-1:0] new_exp;
  logic [DEN_W-1:0] denom;
  logic             special;

  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [NUM_W-1:0] div_quot;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = (state_r == ST_IDLE);
  assign in_fire       = in_bus.valid && in_bus.ready;

  // Index check: both the programmed count and the built-in channel limit apply
  always_comb begin
    idx_ok  = (in_bus.fan_index < fan_count_r) &&
              ({1'b0, in_bus.fan_index} < (IDX_W + 1)'(MAX_FANS));
    sel     = in_bus.fan_index[SEL_W-1:0];
    old_exp = idx_ok ? fan_exp_r[sel] : '0;
    new_exp = old_exp;
    if (in_bus.tach_count > COUNT_HIGH && old_exp < EXP_MAX) begin
      new_exp = old_exp + 1'b1;
    end else if (in_bus.tach_count < COUNT_LOW && old_exp != '0) begin
      new_exp = old_exp - 1'b1;
    end
    denom   = DEN_W'(in_bus.tach_count) << old_exp;
    // Rejected index, absent fan and zero count bypass the divider
    special = !idx_ok || (in_bus.tach_count == COUNT_ABSENT) || (in_bus.tach_count == '0);
  end

  assign div_ctl.start = in_fire && !special;

  ftad_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .denom (denom),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt   = state_r;
    chan_nxt    = chan_r;
    rpm_nxt     = rpm_r;
    exp_nxt     = exp_r;
    old_exp_nxt = old_exp_r;
    chg_nxt     = chg_r;
    acc_nxt     = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          chan_nxt    = in_bus.fan_index;
          acc_nxt     = idx_ok;
          old_exp_nxt = old_exp;
          exp_nxt     = idx_ok ? new_exp : '0;
          chg_nxt     = idx_ok && (new_exp != old_exp);
          if (!idx_ok || in_bus.tach_count == COUNT_ABSENT) begin
            rpm_nxt = '0;
          end else begin
            rpm_nxt = RPM_NUMERATOR;
          end
          state_nxt = special ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          rpm_nxt   = div_quot;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_bus.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fan_count_r <= FAN_COUNT_RST;
      for (int i = 0; i < int'(MAX_FANS); i++) begin
        fan_exp_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid && cfg_bus.ready) begin
        fan_count_r <= cfg_bus.data;
      end
      // Write back the ranged exponent at accept; rejected beats leave it alone
      if (in_fire && idx_ok) begin
        fan_exp_r[sel] <= new_exp;
      end
    end
  end

  always_ff @(posedge clk) begin
    chan_r    <= chan_nxt;
    rpm_r     <= rpm_nxt;
    exp_r     <= exp_nxt;
    old_exp_r <= old_exp_nxt;
    chg_r     <= chg_nxt;
    acc_r     <= acc_nxt;
  end

  assign out_bus.valid            = (state_r == ST_OUT);
  assign out_bus.fan_channel      = chan_r;
  assign out_bus.rpm              = rpm_r;
  assign out_bus.divisor_exponent = exp_r;
  assign out_bus.divisor_changed  = chg_r;
  assign out_bus.accepted         = acc_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> !out_bus.valid && !div_sts.busy)
    else $error("input ready while a beat is still in flight");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.accepted |->
      out_bus.rpm == '0 && out_bus.divisor_exponent == '0 && !out_bus.divisor_changed)
    else $error("rejected beat carries nonzero result fields");

  a_change_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.divisor_changed |->
      out_bus.divisor_exponent == old_exp_r + 1'b1 ||
      out_bus.divisor_exponent == old_exp_r - 1'b1)
    else $error("divisor exponent moved by other than one step");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ftad_pkg::*;

  // Result of one tachometer beat, in the order the result channel carries it.
  typedef struct packed {
    logic [IDX_W-1:0] fan_channel;
    logic [NUM_W-1:0] rpm;
    logic [EXP_W-1:0] divisor_exponent;
    logic             divisor_changed;
    logic             accepted;
  } fan_speed_t;

  // One row of the opening probe table. When typed is set, want is the result
  // that the row must give; otherwise the speed predictor supplies it.
  typedef struct packed {
    logic [IDX_W-1:0]   fan_index;
    logic [COUNT_W-1:0] tach_count;
    logic               typed;
    fan_speed_t         want;
  } tach_row_t;

  localparam int PROBE_ROWS   = 24;
  localparam int SETTINGS_N   = 8;
  localparam int DRAIN_CYCLES = 30;     // a bit more than one full divide
  localparam int LONG_HOLD    = 400;    // output hold-off, far longer than a beat
  localparam int HOLD_PHASE   = 4;
  localparam longint TIMEOUT_NS = 64'd30_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ftad_in_if  in_if ();
  ftad_out_if out_if ();
  ftad_cfg_if cfg_if ();

  fan_tach_autorange_divisor u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's state, advanced once per accepted beat.
  logic [EXP_W-1:0] div_exp_by_fan [FTAD_MAX_FANS];
  logic [IDX_W-1:0] fan_count_cfg;

  // Speeds still owed by the block, oldest first.
  fan_speed_t pending_speeds [$];

  int errors      = 0;
  int beats_in    = 0;
  int results_out = 0;
  int rejected    = 0;
  int exp_moves   = 0;
  int cfg_writes  = 0;
  int long_holds  = 0;

  // Idling switches and the one-shot request for the long output hold-off.
  bit src_idles      = 1'b0;
  bit sink_idles     = 1'b0;
  bit long_hold_req  = 1'b0;

  // Opening probes: reset state, count extremes, the auto-range thresholds on
  // both sides, exponent saturation at 7 and at 0, absent fan, zero count and
  // rejected indices. Rows that depend on a moved exponent go to the predictor.
  tach_row_t probe_rows [PROBE_ROWS] = '{
    '{3'd0, 8'd255, 1'b1, '{3'd0, 21'd0,       3'd1, 1'b1, 1'b1}},
    '{3'd0, 8'd0,   1'b1, '{3'd0, 21'd1350000, 3'd0, 1'b1, 1'b1}},
    '{3'd1, 8'd1,   1'b1, '{3'd1, 21'd1350000, 3'd0, 1'b0, 1'b1}},
    '{3'd1, 8'd192, 1'b1, '{3'd1, 21'd7031,    3'd0, 1'b0, 1'b1}},
    '{3'd1, 8'd96,  1'b1, '{3'd1, 21'd14062,   3'd0, 1'b0, 1'b1}},
    '{3'd1, 8'd95,  1'b0, '0},
    '{3'd1, 8'd193, 1'b0, '0},
    '{3'd1, 8'd193, 1'b0, '0},
    '{3'd2, 8'd200, 1'b0, '0},
    '{3'd2, 8'd200, 1'b0, '0},
    '{3'd2, 8'd200, 1'b0, '0},
    '{3'd2, 8'd200, 1'b0, '0},
    '{3'd2, 8'd200, 1'b0, '0},
    '{3'd2, 8'd200, 1'b0, '0},
    '{3'd2, 8'd200, 1'b0, '0},
    '{3'd2, 8'd200, 1'b0, '0},
    '{3'd2, 8'd1,   1'b0, '0},
    '{3'd2, 8'd254, 1'b0, '0},
    '{3'd2, 8'd255, 1'b0, '0},
    '{3'd4, 8'd128, 1'b1, '{3'd4, 21'd10546,   3'd0, 1'b0, 1'b1}},
    '{3'd5, 8'd100, 1'b1, '{3'd5, 21'd0,       3'd0, 1'b0, 1'b0}},
    '{3'd7, 8'd255, 1'b1, '{3'd7, 21'd0,       3'd0, 1'b0, 1'b0}},
    '{3'd6, 8'd0,   1'b1, '{3'd6, 21'd0,       3'd0, 1'b0, 1'b0}},
    '{3'd3, 8'd97,  1'b0, '0}
  };

  // fan_count settings, one per random phase: reset value, both ends of the
  // legal range, zero and the two values above the number of fans.
  logic [IDX_W-1:0] fan_count_plan [SETTINGS_N] = '{
    3'd5, 3'd1, 3'd0, 3'd7, 3'd3, 3'd6, 3'd2, 3'd4
  };

  // Predict the speed for one beat and advance the shadow exponent.
  function automatic fan_speed_t next_fan_speed(input logic [IDX_W-1:0] idx,
                                                input logic [COUNT_W-1:0] count);
    fan_speed_t       r;
    logic [EXP_W-1:0] old_e;
    logic [EXP_W-1:0] new_e;
    int unsigned      active;
    int unsigned      denom;
    r = '0;
    r.fan_channel = idx;
    // Settings above the number of fans act as the number of fans.
    active = (fan_count_cfg > FTAD_MAX_FANS) ? FTAD_MAX_FANS : fan_count_cfg;
    if (idx >= active) begin
      return r;
    end
    old_e = div_exp_by_fan[idx];
    if (count == COUNT_ABSENT) begin
      r.rpm = '0;
    end else if (count == '0) begin
      r.rpm = RPM_NUMERATOR;
    end else begin
      denom = 32'(count) << old_e;
      r.rpm = NUM_W'(32'(RPM_NUMERATOR) / denom);
    end
    // Step the exponent by at most one, up before down.
    new_e = old_e;
    if (count > COUNT_HIGH && old_e < EXP_MAX) begin
      new_e = old_e + 3'd1;
    end else if (count < COUNT_LOW && old_e != '0) begin
      new_e = old_e - 3'd1;
    end
    div_exp_by_fan[idx] = new_e;
    r.divisor_exponent = new_e;
    r.divisor_changed  = (new_e != old_e);
    r.accepted         = 1'b1;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(20, 80);
    end
    return $urandom_range(0, 3);
  endfunction

  // Pick a count for a burst: 0 pushes the exponent up, 1 pulls it down,
  // anything else is spread over the whole range. Edge values show up in all.
  function automatic logic [COUNT_W-1:0] pick_count(input int dir);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return COUNT_ABSENT;
    end else if (r == 2) begin
      return (dir == 1) ? COUNT_LOW : COUNT_HIGH;
    end else if (r == 3) begin
      return (dir == 1) ? COUNT_LOW - 8'd1 : COUNT_HIGH + 8'd1;
    end
    case (dir)
      0:       return COUNT_W'($urandom_range(193, 254));
      1:       return COUNT_W'($urandom_range(1, 95));
      default: return COUNT_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one beat, hold it until accepted, then log what it must produce.
  // Valid stays high into the next beat unless a gap is drawn.
  task automatic send_beat(input logic [IDX_W-1:0] idx, input logic [COUNT_W-1:0] count,
                           input logic typed, input fan_speed_t want);
    fan_speed_t guess;
    int         gap;
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.fan_index  <= idx;
    in_if.tach_count <= count;
    forever begin
      @(posedge clk);
      if (in_if.ready) break;
    end
    // Always run the predictor so the shadow exponents track typed rows too.
    guess = next_fan_speed(idx, count);
    pending_speeds.push_back(typed ? want : guess);
    beats_in++;
    gap = src_idles ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, wait until every owed speed has come back, then let the
  // block settle.
  task automatic quiesce();
    if (in_if.valid) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write fan_count while the block is idle and mirror it in the shadow copy.
  task automatic write_fan_count(input logic [IDX_W-1:0] value);
    quiesce();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_if.ready) break;
    end
    fan_count_cfg = value;
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Random beats, mostly bursts on one live fan that walk its exponent up or
  // down, mixed with noise that hits any index including rejected ones.
  task automatic run_random(input int n);
    int               sent;
    int               eff;
    int               len;
    int               dir;
    logic [IDX_W-1:0] fan;
    sent = 0;
    eff  = (fan_count_cfg > FTAD_MAX_FANS) ? FTAD_MAX_FANS : fan_count_cfg;
    while (sent < n) begin
      if (eff == 0 || $urandom_range(0, 9) == 0) begin
        send_beat(IDX_W'($urandom_range(0, 7)), COUNT_W'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end else begin
        fan = IDX_W'($urandom_range(0, eff - 1));
        len = $urandom_range(1, 8);
        dir = $urandom_range(0, 2);
        for (int k = 0; k < len && sent < n; k++) begin
          send_beat(fan, pick_count(dir), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result sink: one ready decision per falling edge. A single counter holds
  // ready low for both the short random stalls and the long hold-off.
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        long_holds++;
        out_if.ready <= 1'b0;
      end else if (sink_idles && $urandom_range(0, 3) == 0) begin
        hold_left = gap_len();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest owed speed, field by field.
  always @(posedge clk) begin : result_check
    fan_speed_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_out++;
      if (out_if.accepted === 1'b0) rejected++;
      if (out_if.divisor_changed === 1'b1) exp_moves++;
      if (pending_speeds.size() == 0) begin
        $display("%0t: result beat with none expected: channel %0d rpm %0d", $time,
                 out_if.fan_channel, out_if.rpm);
        errors++;
      end else begin
        want = pending_speeds.pop_front();
        check_field("fan_channel", 32'(want.fan_channel), 32'(out_if.fan_channel));
        check_field("rpm", 32'(want.rpm), 32'(out_if.rpm));
        check_field("divisor_exponent", 32'(want.divisor_exponent),
                    32'(out_if.divisor_exponent));
        check_field("divisor_changed", 32'(want.divisor_changed),
                    32'(out_if.divisor_changed));
        check_field("accepted", 32'(want.accepted), 32'(out_if.accepted));
      end
    end
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still owed", pending_speeds.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    in_if.valid      = 1'b0;
    in_if.fan_index  = '0;
    in_if.tach_count = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    fan_count_cfg    = FAN_COUNT_RST;
    for (int f = 0; f < FTAD_MAX_FANS; f++) div_exp_by_fan[f] = '0;

    // Hold reset, release on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the probe table from the reset state, with idling on both sides.
    src_idles  = 1'b1;
    sink_idles = 1'b1;
    for (int i = 0; i < PROBE_ROWS; i++) begin
      send_beat(probe_rows[i].fan_index, probe_rows[i].tach_count,
                probe_rows[i].typed, probe_rows[i].want);
    end

    // Random phases, one per fan_count setting. The first runs with no
    // idling at all; the others vary which side idles.
    for (int ph = 0; ph < SETTINGS_N; ph++) begin
      write_fan_count(fan_count_plan[ph]);
      src_idles  = (ph % 3) != 0;
      sink_idles = (ph % 2) != 0;
      // Back the output up for a long stretch while beats keep coming.
      if (ph == HOLD_PHASE) long_hold_req = 1'b1;
      run_random((fan_count_plan[ph] == '0) ? 60 : 220);
    end

    quiesce();
    if (pending_speeds.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_speeds.size());
      errors++;
    end

    $display("Ran %0d tach beats through %0d fan_count writes; %0d results back, %0d rejected,",
             beats_in, cfg_writes, results_out, rejected);
    $display("%0d divisor steps, %0d long output hold-off(s), %0d mismatches.",
             exp_moves, long_holds, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
design/ftad_pkg.sv
design/ftad_if.sv
design/ftad_div.sv
design/fan_tach_autorange_divisor.sv
tb/sv/tb.sv
